@@ rtl/byte_ring_fifo_with_records_assert.svh @@
// Assertion macros for the byte ring FIFO with records.
`ifndef BYTE_RING_FIFO_WITH_RECORDS_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_RECORDS_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define BRF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/brf_pkg.sv @@
// Shared constants, codes and types of the byte ring FIFO with records.
package brf_pkg;

   localparam int DEPTH_LOG2 = 10;
   localparam int DEPTH      = 1 << DEPTH_LOG2;
   localparam int PTR_W      = DEPTH_LOG2 + 1;
   localparam int HDR_BYTES  = 4;

   localparam int ACT_W  = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 11;
   localparam int LEN_W  = 10;
   localparam int HDR_W  = 32;
   localparam int CAP_W  = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = 4'd10;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = '0;

   localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SKIP   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_COMMIT = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BEGIN  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_OPEN   = 3'd5;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } brf_cmd_type;

   typedef struct packed {
      logic last;
   } brf_sts_type;

   typedef struct packed {
      logic                  accepted;
      logic [BYTE_W-1:0]     read_byte;
      logic [HDR_W-1:0]      record_length_out;
      logic [PTR_W-1:0]      readable_bytes;
      logic [PTR_W-1:0]      writable_bytes;
      logic [PTR_W-1:0]      read_span;
      logic [DEPTH_LOG2-1:0] read_offset;
      logic [PTR_W-1:0]      write_span;
      logic [DEPTH_LOG2-1:0] write_offset;
      logic                  is_empty;
      logic                  is_full;
   } brf_rsp_type;

endpackage

@@ rtl/brf_if.sv @@
// Request and response channel interfaces of the byte ring FIFO with records.
interface brf_req_if;
   logic                          valid;
   logic                          ready;
   logic [brf_pkg::ACT_W-1:0]     action;
   logic [brf_pkg::BYTE_W-1:0]    data_byte;
   logic [brf_pkg::CNT_W-1:0]     advance_count;
   logic [brf_pkg::LEN_W-1:0]     record_length;

   modport source (output valid, action, data_byte, advance_count, record_length,
                   input ready);
   modport sink (input valid, action, data_byte, advance_count, record_length,
                 output ready);
endinterface

interface brf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            accepted;
   logic [brf_pkg::BYTE_W-1:0]      read_byte;
   logic [brf_pkg::HDR_W-1:0]       record_length_out;
   logic [brf_pkg::PTR_W-1:0]       readable_bytes;
   logic [brf_pkg::PTR_W-1:0]       writable_bytes;
   logic [brf_pkg::PTR_W-1:0]       read_span;
   logic [brf_pkg::DEPTH_LOG2-1:0]  read_offset;
   logic [brf_pkg::PTR_W-1:0]       write_span;
   logic [brf_pkg::DEPTH_LOG2-1:0]  write_offset;
   logic                            is_empty;
   logic                            is_full;

   modport source (output valid, accepted, read_byte, record_length_out, readable_bytes,
                   writable_bytes, read_span, read_offset, write_span, write_offset,
                   is_empty, is_full,
                   input ready);
   modport sink (input valid, accepted, read_byte, record_length_out, readable_bytes,
                 writable_bytes, read_span, read_offset, write_span, write_offset,
                 is_empty, is_full,
                 output ready);
endinterface

@@ rtl/brf_ctrl.sv @@
// Sequencing state machine of the byte ring FIFO with records.
module brf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  brf_pkg::brf_sts_type sts,
   output brf_pkg::brf_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SETTLE = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.step = 1'b1;
            if (sts.last) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/brf_dp.sv @@
// Pointers, byte store and result register of the byte ring FIFO with records.
module brf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  brf_pkg::brf_cmd_type          cmd,
   output brf_pkg::brf_sts_type          sts,
   input  logic [brf_pkg::CAP_W-1:0]     cap_log2,
   input  logic                          clear,
   input  logic [brf_pkg::ACT_W-1:0]     action,
   input  logic [brf_pkg::BYTE_W-1:0]    data_byte,
   input  logic [brf_pkg::CNT_W-1:0]     advance_count,
   input  logic [brf_pkg::LEN_W-1:0]     record_length,
   output brf_pkg::brf_rsp_type          rsp
);

   logic [brf_pkg::BYTE_W-1:0]     byte_store_ff [brf_pkg::DEPTH];
   logic [brf_pkg::BYTE_W-1:0]     rdata_ff;

   logic [brf_pkg::PTR_W-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [brf_pkg::ACT_W-1:0]      act_ff;
   logic [brf_pkg::BYTE_W-1:0]     data_ff;
   logic [brf_pkg::PTR_W-1:0]      adv_ff, adv_in;
   logic [brf_pkg::HDR_W-1:0]      hdr_ff, hdr_in;
   logic                           ok_ff, ok_in;
   logic [1:0]                     step_ff, step_in;
   logic                           pend_ff, pend_in;
   logic [brf_pkg::BYTE_W-1:0]     byte_ff, byte_in;
   brf_pkg::brf_rsp_type           rsp_ff, rsp_in;

   logic [brf_pkg::CAP_W-1:0]      lg;
   logic [brf_pkg::PTR_W-1:0]      cap, rd_now, wr_now, rroom, wroom;
   logic [brf_pkg::DEPTH_LOG2-1:0] mask, roff, woff;
   logic [brf_pkg::CNT_W-1:0]      need;
   logic                           we, multi;
   logic [brf_pkg::BYTE_W-1:0]     wdata;

   always_comb begin
      if (cap_log2 == '0) begin
         lg = brf_pkg::CAP_W'(1);
      end else if (cap_log2 > brf_pkg::CAP_W'(brf_pkg::DEPTH_LOG2)) begin
         lg = brf_pkg::CAP_W'(brf_pkg::DEPTH_LOG2);
      end else begin
         lg = cap_log2;
      end
   end

   assign cap    = brf_pkg::PTR_W'(1) << lg;
   assign mask   = cap[brf_pkg::DEPTH_LOG2-1:0] - brf_pkg::DEPTH_LOG2'(1);
   assign rd_now = wp_ff - rp_ff;
   assign wr_now = cap - rd_now;
   assign roff   = rp_ff[brf_pkg::DEPTH_LOG2-1:0] & mask;
   assign woff   = wp_ff[brf_pkg::DEPTH_LOG2-1:0] & mask;
   assign rroom  = cap - {1'b0, roff};
   assign wroom  = cap - {1'b0, woff};
   assign need   = brf_pkg::CNT_W'(record_length) + brf_pkg::CNT_W'(brf_pkg::HDR_BYTES);

   // decide at accept time, pointers are the same as at the first step
   always_comb begin
      ok_in  = 1'b0;
      adv_in = '0;
      case (action)
         brf_pkg::ACT_PUSH:   ok_in = (wr_now != '0);
         brf_pkg::ACT_POP:    ok_in = (rd_now != '0);
         brf_pkg::ACT_SKIP: begin
            ok_in  = (advance_count <= rd_now);
            adv_in = ok_in ? advance_count : rd_now;
         end
         brf_pkg::ACT_COMMIT: begin
            ok_in  = (advance_count <= wr_now);
            adv_in = ok_in ? advance_count : wr_now;
         end
         brf_pkg::ACT_BEGIN:  ok_in = (wr_now >= need);
         brf_pkg::ACT_OPEN:   ok_in = (rd_now > brf_pkg::PTR_W'(brf_pkg::HDR_BYTES));
         default:             ok_in = 1'b0;
      endcase
   end

   assign multi    = ok_ff && (act_ff == brf_pkg::ACT_BEGIN || act_ff == brf_pkg::ACT_OPEN);
   assign sts.last = !multi || (step_ff == 2'd3);

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      hdr_in  = hdr_ff;
      byte_in = byte_ff;
      step_in = step_ff;
      pend_in = 1'b0;
      we      = 1'b0;
      wdata   = data_ff;
      // take the byte read on the previous step
      if (pend_ff) begin
         byte_in = rdata_ff;
         hdr_in  = {rdata_ff, hdr_ff[brf_pkg::HDR_W-1:brf_pkg::BYTE_W]};
      end
      if (cmd.load) begin
         step_in = '0;
         byte_in = '0;
         hdr_in  = (action == brf_pkg::ACT_BEGIN) ? brf_pkg::HDR_W'(record_length) : '0;
      end else if (cmd.step) begin
         step_in = step_ff + 2'd1;
         case (act_ff)
            brf_pkg::ACT_PUSH: begin
               if (ok_ff) begin
                  we    = 1'b1;
                  wp_in = wp_ff + brf_pkg::PTR_W'(1);
               end
            end
            brf_pkg::ACT_BEGIN: begin
               if (ok_ff) begin
                  we     = 1'b1;
                  wdata  = hdr_ff[brf_pkg::BYTE_W-1:0];
                  hdr_in = hdr_ff >> brf_pkg::BYTE_W;
                  wp_in  = wp_ff + brf_pkg::PTR_W'(1);
               end
            end
            brf_pkg::ACT_POP, brf_pkg::ACT_OPEN: begin
               if (ok_ff) begin
                  pend_in = 1'b1;
                  rp_in   = rp_ff + brf_pkg::PTR_W'(1);
               end
            end
            brf_pkg::ACT_SKIP:   rp_in = rp_ff + adv_ff;
            brf_pkg::ACT_COMMIT: wp_in = wp_ff + adv_ff;
            default: ;
         endcase
      end
      if (clear) begin
         wp_in = '0;
         rp_in = '0;
      end
   end

   always_comb begin
      rsp_in                   = '0;
      rsp_in.accepted          = ok_ff;
      rsp_in.read_byte         = (act_ff == brf_pkg::ACT_POP) ? byte_ff : '0;
      rsp_in.record_length_out = (act_ff == brf_pkg::ACT_OPEN) ? hdr_ff : '0;
      rsp_in.readable_bytes    = rd_now;
      rsp_in.writable_bytes    = wr_now;
      rsp_in.read_span         = (rroom < rd_now) ? rroom : rd_now;
      rsp_in.read_offset       = roff;
      rsp_in.write_span        = (wroom < wr_now) ? wroom : wr_now;
      rsp_in.write_offset      = woff;
      rsp_in.is_empty          = (rd_now == '0);
      rsp_in.is_full           = (rd_now == cap);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         byte_store_ff[woff] <= wdata;
      end
      rdata_ff <= byte_store_ff[roff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         pend_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= action;
         data_ff <= data_byte;
         adv_ff  <= adv_in;
         ok_ff   <= ok_in;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
      hdr_ff  <= hdr_in;
      byte_ff <= byte_in;
      step_ff <= step_in;
   end

   assign rsp = rsp_ff;

endmodule

@@ rtl/byte_ring_fifo_with_records.sv @@
// Top level of the byte ring FIFO with records: channels, register port, assertions.
//
//   channel  | direction | payload
//   ---------+-----------+-------------------------------------------------
//   req_bus  | in        | action, data_byte, advance_count, record_length
//   rsp_bus  | out       | accepted, read_byte, record_length_out, counts
//   csr_*    | in/out    | capacity_log2 at byte address 0
//
// Accept leads through execute, settle and done to the result, run by the controller;
// only an accepted begin or open stays in execute past its first step, one header byte
// per cycle through the byte store with its registered read.
// The next beat is taken in the cycle the result appears.
// Reset empties the ring and sets capacity_log2 to 10; the byte store is not cleared.
// A result waiting in the output register does not block the next accept.
`include "byte_ring_fifo_with_records_assert.svh"

module byte_ring_fifo_with_records (
   input  logic                              clock,
   input  logic                              reset,
   brf_req_if.sink                           req_bus,
   brf_rsp_if.source                         rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [brf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [brf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [brf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [brf_pkg::CAP_W-1:0] cap_ff, cap_in;
   logic                      cap_hit, cap_wr;
   brf_pkg::brf_cmd_type      cmd;
   brf_pkg::brf_sts_type      sts;
   brf_pkg::brf_rsp_type      rsp;

   assign csr_pready = 1'b1;
   assign cap_hit    = (csr_paddr[brf_pkg::CSR_ADDR_W-1:2] == brf_pkg::REG_CAPACITY);
   assign cap_wr     = csr_psel && csr_penable && csr_pwrite && cap_hit;
   assign cap_in     = cap_wr ? csr_pwdata[brf_pkg::CAP_W-1:0] : cap_ff;
   assign csr_prdata = cap_hit ? brf_pkg::CSR_DATA_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= brf_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   brf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .cap_log2      (cap_ff),
      .clear         (cap_wr),
      .action        (req_bus.action),
      .data_byte     (req_bus.data_byte),
      .advance_count (req_bus.advance_count),
      .record_length (req_bus.record_length),
      .rsp           (rsp)
   );

   assign rsp_bus.accepted          = rsp.accepted;
   assign rsp_bus.read_byte         = rsp.read_byte;
   assign rsp_bus.record_length_out = rsp.record_length_out;
   assign rsp_bus.readable_bytes    = rsp.readable_bytes;
   assign rsp_bus.writable_bytes    = rsp.writable_bytes;
   assign rsp_bus.read_span         = rsp.read_span;
   assign rsp_bus.read_offset       = rsp.read_offset;
   assign rsp_bus.write_span        = rsp.write_span;
   assign rsp_bus.write_offset      = rsp.write_offset;
   assign rsp_bus.is_empty          = rsp.is_empty;
   assign rsp_bus.is_full           = rsp.is_full;

   `BRF_ASSERT_NEXT(a_one_in_flight, req_bus.valid && req_bus.ready, !req_bus.ready, "beat accepted while an item is in flight")
   `BRF_ASSERT_NOW(a_spans_bounded, rsp_bus.valid, (rsp_bus.read_span <= rsp_bus.readable_bytes) && (rsp_bus.write_span <= rsp_bus.writable_bytes), "span exceeds byte count")
   `BRF_ASSERT_NOW(a_full_no_room, rsp_bus.valid && rsp_bus.is_full, rsp_bus.writable_bytes == '0, "full ring reports free bytes")
   `BRF_ASSERT_NOW(a_empty_no_data, rsp_bus.valid && rsp_bus.is_empty, rsp_bus.readable_bytes == '0, "empty ring reports stored bytes")

endmodule

@@ verif/byte_ring_fifo_with_records_test.sv @@
// Self-checking testbench for the byte ring FIFO with records: random and directed beats.
module byte_ring_fifo_with_records_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 1;
   localparam int RESET_CYCLES = 9;
   localparam int LIMIT_CYCLES = 250000;
   localparam int TAIL_CYCLES  = 20;
   localparam int HOLD_CYCLES  = 300;
   localparam int ITEMS        = 1750;
   localparam int NUM_PHASES   = 12;
   localparam int PRESS_PHASE  = 4;
   localparam int PLAN         = 0;
   localparam int LIVE         = 1;
   localparam int MAX_COUNT    = (1 << brf_pkg::CNT_W) - 1;
   localparam int MAX_LEN      = (1 << brf_pkg::LEN_W) - 1;

   localparam logic [brf_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
   localparam logic [brf_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;

   localparam int CAP_STEPS [NUM_PHASES] = '{3, 1, 0, 15, 10, 2, 5, 10, 4, 7, 12, 6};

   typedef struct packed {
      logic [brf_pkg::ACT_W-1:0]  action;
      logic [brf_pkg::BYTE_W-1:0] data_byte;
      logic [brf_pkg::CNT_W-1:0]  advance_count;
      logic [brf_pkg::LEN_W-1:0]  record_length;
   } fifo_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [brf_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [brf_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [brf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   brf_req_if req_bus ();
   brf_rsp_if rsp_bus ();

   byte_ring_fifo_with_records i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // two copies of the ring: one steered by the stimulus planner, one advanced on accepted beats
   logic [brf_pkg::BYTE_W-1:0] ring_mem    [2][brf_pkg::DEPTH];
   bit                         ring_filled [2][brf_pkg::DEPTH];
   logic [brf_pkg::PTR_W-1:0]  ring_wp [2];
   logic [brf_pkg::PTR_W-1:0]  ring_rp [2];
   logic [brf_pkg::CAP_W-1:0]  ring_lg [2];

   fifo_op_type          op_queue[$];
   brf_pkg::brf_rsp_type ring_expect[$];
   int                   open_records[$];

   bit   plan_ok;
   bit   records_broken;
   int   ops_planned;
   int   send_idle_pct;
   int   recv_stall_pct;
   logic long_hold = 1'b0;
   event hold_kick;

   int fails;
   int csr_fails;
   int beats_in;
   int beats_checked;
   int records_opened;
   int full_seen;
   int refused_seen;
   int cycle_count;

   function automatic int ring_cap(int m);
      int lg;
      lg = ring_lg[m];
      if (lg < 1) lg = 1;
      if (lg > brf_pkg::DEPTH_LOG2) lg = brf_pkg::DEPTH_LOG2;
      return 1 << lg;
   endfunction

   function automatic int ring_level(int m);
      logic [brf_pkg::PTR_W-1:0] diff;
      diff = ring_wp[m] - ring_rp[m];
      return int'(diff);
   endfunction

   function automatic void ring_reset(int m, logic [brf_pkg::CAP_W-1:0] lg);
      ring_lg[m] = lg;
      ring_wp[m] = '0;
      ring_rp[m] = '0;
   endfunction

   function automatic void put_byte(int m, logic [brf_pkg::BYTE_W-1:0] v);
      int idx;
      idx = int'(ring_wp[m]) & (ring_cap(m) - 1);
      ring_mem[m][idx]    = v;
      ring_filled[m][idx] = 1'b1;
      ring_wp[m]          = ring_wp[m] + 1'b1;
   endfunction

   function automatic logic [brf_pkg::BYTE_W-1:0] take_byte(int m);
      int idx;
      idx = int'(ring_rp[m]) & (ring_cap(m) - 1);
      ring_rp[m] = ring_rp[m] + 1'b1;
      return ring_mem[m][idx];
   endfunction

   function automatic bit ring_stale(int m, int n);
      for (int i = 0; i < n; i++) begin
         if (!ring_filled[m][(int'(ring_rp[m]) + i) & (ring_cap(m) - 1)]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic brf_pkg::brf_rsp_type ring_step(int m, fifo_op_type op);
      brf_pkg::brf_rsp_type res;
      int                   cap, rd, wr, n, roff, woff, len;
      res  = '0;
      cap  = ring_cap(m);
      rd   = ring_level(m);
      wr   = cap - rd;
      len  = int'(op.record_length);
      case (op.action)
         brf_pkg::ACT_PUSH: begin
            if (wr > 0) begin
               put_byte(m, op.data_byte);
               res.accepted = 1'b1;
            end
         end
         brf_pkg::ACT_POP: begin
            if (rd > 0) begin
               res.read_byte = take_byte(m);
               res.accepted  = 1'b1;
            end
         end
         brf_pkg::ACT_SKIP: begin
            n = (int'(op.advance_count) < rd) ? int'(op.advance_count) : rd;
            ring_rp[m]   = ring_rp[m] + brf_pkg::PTR_W'(n);
            res.accepted = (n == int'(op.advance_count));
         end
         brf_pkg::ACT_COMMIT: begin
            n = (int'(op.advance_count) < wr) ? int'(op.advance_count) : wr;
            ring_wp[m]   = ring_wp[m] + brf_pkg::PTR_W'(n);
            res.accepted = (n == int'(op.advance_count));
         end
         brf_pkg::ACT_BEGIN: begin
            if (wr >= len + brf_pkg::HDR_BYTES) begin
               for (int i = 0; i < brf_pkg::HDR_BYTES; i++) begin
                  put_byte(m, brf_pkg::BYTE_W'(len >> (8 * i)));
               end
               res.accepted = 1'b1;
            end
         end
         brf_pkg::ACT_OPEN: begin
            if (rd > brf_pkg::HDR_BYTES) begin
               for (int i = 0; i < brf_pkg::HDR_BYTES; i++) begin
                  res.record_length_out = res.record_length_out
                                        | (brf_pkg::HDR_W'(take_byte(m)) << (8 * i));
               end
               res.accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rd   = ring_level(m);
      wr   = cap - rd;
      roff = int'(ring_rp[m]) & (cap - 1);
      woff = int'(ring_wp[m]) & (cap - 1);
      res.readable_bytes = brf_pkg::PTR_W'(rd);
      res.writable_bytes = brf_pkg::PTR_W'(wr);
      res.read_span      = brf_pkg::PTR_W'((cap - roff < rd) ? cap - roff : rd);
      res.read_offset    = brf_pkg::DEPTH_LOG2'(roff);
      res.write_span     = brf_pkg::PTR_W'((cap - woff < wr) ? cap - woff : wr);
      res.write_offset   = brf_pkg::DEPTH_LOG2'(woff);
      res.is_empty       = (rd == 0);
      res.is_full        = (rd == cap);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [brf_pkg::HDR_W-1:0] want,
                              input logic [brf_pkg::HDR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         fails++;
      end
   endtask

   // never read an entry that no push or begin has written
   task automatic plan_op(input logic [brf_pkg::ACT_W-1:0] act, input int data,
                          input int count, input int len);
      fifo_op_type          op;
      brf_pkg::brf_rsp_type res;
      int                   lvl;
      op.action        = act;
      op.data_byte     = brf_pkg::BYTE_W'(data);
      op.advance_count = brf_pkg::CNT_W'(count);
      op.record_length = brf_pkg::LEN_W'(len);
      lvl = ring_level(PLAN);
      if ((act == brf_pkg::ACT_POP && lvl > 0 && ring_stale(PLAN, 1))
          || (act == brf_pkg::ACT_OPEN && lvl > brf_pkg::HDR_BYTES
              && ring_stale(PLAN, brf_pkg::HDR_BYTES))) begin
         op.action        = brf_pkg::ACT_SKIP;
         op.advance_count = (act == brf_pkg::ACT_POP) ? brf_pkg::CNT_W'(1)
                                                      : brf_pkg::CNT_W'(brf_pkg::HDR_BYTES);
         records_broken   = 1'b1;
      end
      res     = ring_step(PLAN, op);
      plan_ok = res.accepted;
      op_queue.push_back(op);
      ops_planned++;
   endtask

   task automatic write_record();
      int top, len, lo;
      top = ring_cap(PLAN) - ring_level(PLAN) - brf_pkg::HDR_BYTES;
      if (top < 0) begin
         len = $urandom_range(0, 3);
      end else if ($urandom_range(0, 7) == 0) begin
         len = (ring_cap(PLAN) <= 64 || top < 40) ? top : 40;
      end else begin
         len = (top < 8) ? $urandom_range(0, top) : $urandom_range(0, 8);
      end
      if ($urandom_range(0, 15) == 0) begin
         lo  = (top + 1 < 0) ? 0 : top + 1;
         len = (ring_cap(PLAN) <= 64) ? $urandom_range(0, MAX_LEN)
                                      : $urandom_range(lo, MAX_LEN);
      end
      plan_op(brf_pkg::ACT_BEGIN, 0, 0, len);
      if (plan_ok) begin
         for (int i = 0; i < len; i++) begin
            plan_op(brf_pkg::ACT_PUSH, $urandom_range(0, 255), 0, 0);
         end
         open_records.push_back(len);
      end
   endtask

   task automatic read_record();
      int len;
      if (records_broken) begin
         plan_op(brf_pkg::ACT_SKIP, 0, $urandom_range(0, 1) ? MAX_COUNT : ring_level(PLAN), 0);
         open_records.delete();
         records_broken = 1'b0;
      end else if (open_records.size() == 0) begin
         plan_op($urandom_range(0, 1) ? brf_pkg::ACT_OPEN : brf_pkg::ACT_POP, 0, 0, 0);
      end else begin
         len = open_records[0];
         plan_op(brf_pkg::ACT_OPEN, 0, 0, 0);
         if (plan_ok) begin
            void'(open_records.pop_front());
            if ($urandom_range(0, 3) == 0) begin
               plan_op(brf_pkg::ACT_SKIP, 0, len, 0);
            end else begin
               for (int i = 0; i < len; i++) plan_op(brf_pkg::ACT_POP, 0, 0, 0);
            end
         end
      end
   endtask

   task automatic noise_op();
      logic [brf_pkg::PTR_W-1:0] wp0, rp0;
      int                        count;
      wp0 = ring_wp[PLAN];
      rp0 = ring_rp[PLAN];
      case ($urandom_range(0, 2))
         0: count = $urandom_range(0, 3);
         1: count = $urandom_range(0, ring_cap(PLAN));
         default: count = $urandom_range(0, MAX_COUNT);
      endcase
      plan_op(brf_pkg::ACT_W'($urandom_range(0, 7)), $urandom_range(0, 255), count,
              $urandom_range(0, MAX_LEN));
      if (ring_wp[PLAN] != wp0 || ring_rp[PLAN] != rp0) records_broken = 1'b1;
   endtask

   task automatic plan_random(input int quota);
      int start, write_bias, roll;
      start      = ops_planned;
      write_bias = $urandom_range(30, 55);
      while (ops_planned - start < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < write_bias) write_record();
         else if (roll < 85) read_record();
         else noise_op();
      end
   endtask

   task automatic wait_ring_idle();
      while (op_queue.size() != 0 || req_bus.valid || ring_expect.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [brf_pkg::CAP_W-1:0] value);
      logic [brf_pkg::CSR_DATA_W-1:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {brf_pkg::REG_CAPACITY, 2'b00};
      csr_pwdata  <= brf_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ring_reset(PLAN, value);
      ring_reset(LIVE, value);
      open_records.delete();
      records_broken = 1'b0;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[brf_pkg::CAP_W-1:0] !== value) begin
         $display("%0t: capacity_log2 readback mismatch, expected 0x%0h, got 0x%0h",
                  $time, value, readback[brf_pkg::CAP_W-1:0]);
         csr_fails++;
      end
   endtask

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  ring_expect.size());
         $display("byte_ring_fifo_with_records_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      fifo_op_type next_op;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (op_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_op = op_queue.pop_front();
            req_bus.action        <= next_op.action;
            req_bus.data_byte     <= next_op.data_byte;
            req_bus.advance_count <= next_op.advance_count;
            req_bus.record_length <= next_op.record_length;
            req_bus.valid         <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !long_hold && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always begin
      @(hold_kick);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      fifo_op_type          beat;
      brf_pkg::brf_rsp_type got, want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            beat = {req_bus.action, req_bus.data_byte, req_bus.advance_count,
                    req_bus.record_length};
            ring_expect.push_back(ring_step(LIVE, beat));
            beats_in++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.accepted, rsp_bus.read_byte, rsp_bus.record_length_out,
                   rsp_bus.readable_bytes, rsp_bus.writable_bytes, rsp_bus.read_span,
                   rsp_bus.read_offset, rsp_bus.write_span, rsp_bus.write_offset,
                   rsp_bus.is_empty, rsp_bus.is_full};
            if (ring_expect.size() == 0) begin
               $display("%0t: result beat with nothing due, got 0x%0h", $time, got);
               fails++;
            end else begin
               want = ring_expect.pop_front();
               beats_checked++;
               if (want.is_full) full_seen++;
               if (!want.accepted) refused_seen++;
               if (want.accepted && want.record_length_out != 0) records_opened++;
               check_field("accepted", brf_pkg::HDR_W'(want.accepted),
                           brf_pkg::HDR_W'(got.accepted));
               check_field("read_byte", brf_pkg::HDR_W'(want.read_byte),
                           brf_pkg::HDR_W'(got.read_byte));
               check_field("record_length_out", want.record_length_out,
                           got.record_length_out);
               check_field("readable_bytes", brf_pkg::HDR_W'(want.readable_bytes),
                           brf_pkg::HDR_W'(got.readable_bytes));
               check_field("writable_bytes", brf_pkg::HDR_W'(want.writable_bytes),
                           brf_pkg::HDR_W'(got.writable_bytes));
               check_field("read_span", brf_pkg::HDR_W'(want.read_span),
                           brf_pkg::HDR_W'(got.read_span));
               check_field("read_offset", brf_pkg::HDR_W'(want.read_offset),
                           brf_pkg::HDR_W'(got.read_offset));
               check_field("write_span", brf_pkg::HDR_W'(want.write_span),
                           brf_pkg::HDR_W'(got.write_span));
               check_field("write_offset", brf_pkg::HDR_W'(want.write_offset),
                           brf_pkg::HDR_W'(got.write_offset));
               check_field("is_empty", brf_pkg::HDR_W'(want.is_empty),
                           brf_pkg::HDR_W'(got.is_empty));
               check_field("is_full", brf_pkg::HDR_W'(want.is_full),
                           brf_pkg::HDR_W'(got.is_full));
            end
         end
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.action        = brf_pkg::ACT_PUSH;
      req_bus.data_byte     = '0;
      req_bus.advance_count = '0;
      req_bus.record_length = '0;
      rsp_bus.ready         = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      ring_reset(PLAN, brf_pkg::CAP_RESET);
      ring_reset(LIVE, brf_pkg::CAP_RESET);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      plan_op(brf_pkg::ACT_OPEN, 0, 0, 0);
      plan_op(brf_pkg::ACT_POP, 0, 0, 0);
      plan_op(brf_pkg::ACT_SKIP, 0, 0, 0);
      plan_op(brf_pkg::ACT_SKIP, 0, MAX_COUNT, 0);
      plan_op(brf_pkg::ACT_COMMIT, 0, 0, 0);
      plan_op(ACT_SPARE6, 255, MAX_COUNT, MAX_LEN);
      plan_op(ACT_SPARE7, 0, 0, 0);
      plan_op(brf_pkg::ACT_BEGIN, 0, 0, 0);
      plan_op(brf_pkg::ACT_OPEN, 0, 0, 0);
      plan_op(brf_pkg::ACT_PUSH, 0, 0, 0);
      plan_op(brf_pkg::ACT_OPEN, 0, 0, 0);
      plan_op(brf_pkg::ACT_POP, 0, 0, 0);
      plan_op(brf_pkg::ACT_BEGIN, 0, 0, MAX_LEN);
      plan_op(brf_pkg::ACT_BEGIN, 0, 0, brf_pkg::DEPTH - brf_pkg::HDR_BYTES);
      plan_op(brf_pkg::ACT_COMMIT, 0, MAX_COUNT, 0);
      plan_op(brf_pkg::ACT_PUSH, 255, 0, 0);
      plan_op(brf_pkg::ACT_BEGIN, 0, 0, 0);
      plan_op(brf_pkg::ACT_OPEN, 0, 0, 0);
      plan_op(brf_pkg::ACT_SKIP, 0, brf_pkg::DEPTH - brf_pkg::HDR_BYTES, 0);
      plan_op(brf_pkg::ACT_COMMIT, 0, brf_pkg::DEPTH, 0);
      plan_op(brf_pkg::ACT_SKIP, 0, brf_pkg::DEPTH, 0);
      plan_op(brf_pkg::ACT_PUSH, 255, 0, 0);
      plan_op(brf_pkg::ACT_POP, 0, 0, 0);
      wait_ring_idle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_write(brf_pkg::CAP_W'(CAP_STEPS[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         if (p == PRESS_PHASE) -> hold_kick;
         plan_random(ITEMS / NUM_PHASES);
         wait_ring_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d request beats over %0d capacity settings, %0d results checked",
               beats_in, NUM_PHASES + 1, beats_checked);
      $display("records opened %0d, ring full %0d times, refused or clamped %0d",
               records_opened, full_seen, refused_seen);
      if (fails == 0 && csr_fails == 0 && ring_expect.size() == 0) begin
         $display("byte_ring_fifo_with_records_test OK");
      end else begin
         $display("byte_ring_fifo_with_records_test NOT OK");
      end
      $finish;
   end

endmodule
